[hw/rtl/bitmap_range_clear_macros.svh]
// Assertion macros shared by the bitmap range-clear RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BITMAP_RANGE_CLEAR_MACROS_SVH
`define BITMAP_RANGE_CLEAR_MACROS_SVH

// Same-cycle implication, reset-gated.
`define BRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset-gated.
`define BRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/brc_pkg.sv]
// Package for the bitmap range-clear block: constants, payload structs,
// status codes, controller state and the command/status bundles.
`timescale 1ns / 1ps

package brc_pkg;

  localparam int unsigned WordBits       = 64;
  localparam int unsigned NumWords       = 64;
  localparam int unsigned WordIdxW       = 6;
  localparam int unsigned BitIdxW        = 6;
  localparam int unsigned StartW         = 12;
  localparam int unsigned LengthW        = 13;
  localparam int unsigned BitmapBitsDef  = 4096;

  typedef enum logic [1:0] {
    ST_CLEARED = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_OOB     = 2'd2
  } status_e;

  typedef struct packed {
    logic [StartW-1:0]  range_start;
    logic [LengthW-1:0] range_length;
  } req_t;

  typedef struct packed {
    logic [WordIdxW-1:0] word_index;
    logic [WordBits-1:0] word_value;
    status_e             status;
    logic                last;
  } res_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture request, fetch first word
    logic advance;  // write current word, emit it, fetch next
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic special;    // request is empty or out of range
    logic last_word;  // current word is the final one of the range
  } dp_status_t;

endpackage

[hw/rtl/brc_datapath.sv]
// Datapath of the bitmap range-clear block: bitmap memory with per-word
// valid bits, range registers, mask logic and result register. Uses brc_pkg.
`timescale 1ns / 1ps
`include "bitmap_range_clear_macros.svh"

module brc_datapath #(
  parameter int unsigned BitmapBits = brc_pkg::BitmapBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brc_pkg::req_t       req_i,
  input  brc_pkg::cmd_t       cmd_i,
  output brc_pkg::dp_status_t status_o,
  output brc_pkg::res_t       result_o,
  output logic                result_valid_o
);
  import brc_pkg::*;

  logic [WordBits-1:0] mem_q [NumWords];
  logic [NumWords-1:0] valid_q;
  logic [WordBits-1:0] rd_q;
  logic                rdv_q;

  logic [WordIdxW-1:0] cur_q, last_w_q;
  logic [BitIdxW-1:0]  lo_q, hi_q;
  logic                first_q;

  res_t res_q, res_d;
  logic res_valid_q;

  logic [LengthW:0]    end_sum;
  logic [LengthW-1:0]  end_m1;
  logic                is_empty, is_oob;
  logic [WordIdxW-1:0] rd_addr;
  logic [BitIdxW-1:0]  lo_eff, hi_eff;
  logic [WordBits-1:0] mask, old_word, new_word;
  logic                at_last;

  // One bit wider than the length so that start plus any length cannot wrap.
  assign end_sum  = (LengthW+1)'(req_i.range_start) + (LengthW+1)'(req_i.range_length);
  assign end_m1   = LengthW'(end_sum - (LengthW+1)'(1));
  assign is_empty = (req_i.range_length == '0);
  assign is_oob   = (end_sum > (LengthW+1)'(BitmapBits));

  assign at_last  = (cur_q == last_w_q);
  assign status_o = '{special: is_empty || is_oob, last_word: at_last};

  // Fetch the first word on load, otherwise the word after the current one.
  assign rd_addr  = cmd_i.load ? req_i.range_start[StartW-1 -: WordIdxW]
                               : cur_q + WordIdxW'(1);

  assign lo_eff   = first_q ? lo_q : '0;
  assign hi_eff   = at_last ? hi_q : '1;
  assign mask     = ({WordBits{1'b1}} << lo_eff) & ({WordBits{1'b1}} >> (~hi_eff));
  assign old_word = rdv_q ? rd_q : '1;
  assign new_word = old_word & ~mask;

  always_comb begin
    res_d = res_q;
    if (cmd_i.load && is_empty) begin
      res_d = '{word_index: '0, word_value: '0, status: ST_EMPTY, last: 1'b1};
    end else if (cmd_i.load && is_oob) begin
      res_d = '{word_index: '0, word_value: '0, status: ST_OOB, last: 1'b1};
    end else if (cmd_i.advance) begin
      res_d = '{word_index: cur_q, word_value: new_word, status: ST_CLEARED,
                last: at_last};
    end
  end

  // Memory: one write and one registered read per cycle, distinct addresses.
  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      mem_q[cur_q] <= new_word;
    end
    if (cmd_i.load || cmd_i.advance) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rdv_q       <= 1'b0;
      res_valid_q <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      res_valid_q <= (cmd_i.load && (is_empty || is_oob)) || cmd_i.advance;
      if (cmd_i.load || cmd_i.advance) begin
        rdv_q <= valid_q[rd_addr];
      end
      if (cmd_i.advance) begin
        valid_q[cur_q] <= 1'b1;
        first_q        <= 1'b0;
      end else if (cmd_i.load) begin
        first_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.load) begin
      cur_q    <= req_i.range_start[StartW-1 -: WordIdxW];
      last_w_q <= end_m1[StartW-1 -: WordIdxW];
      lo_q     <= req_i.range_start[BitIdxW-1:0];
      hi_q     <= end_m1[BitIdxW-1:0];
    end else if (cmd_i.advance) begin
      cur_q <= cur_q + WordIdxW'(1);
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

  `BRC_ASSERT_NOW(a_special_is_last, clk_i, rst_ni,
    res_valid_q && (res_q.status != ST_CLEARED),
    res_q.last && (res_q.word_value == '0) && (res_q.word_index == '0),
    "special result must be a single zero result marked last")
  `BRC_ASSERT_NEXT(a_special_emits, clk_i, rst_ni,
    cmd_i.load && (is_empty || is_oob),
    res_valid_q && res_q.last && (res_q.status != ST_CLEARED),
    "rejected request did not produce its result")
  `BRC_ASSERT_NEXT(a_advance_emits, clk_i, rst_ni,
    cmd_i.advance,
    res_valid_q && (res_q.status == ST_CLEARED) && (res_q.word_index == $past(cur_q)),
    "word update did not produce a cleared-word result")

endmodule

[hw/rtl/brc_ctrl.sv]
// Controller of the bitmap range-clear block: two-state machine that
// sequences load and per-word updates. Uses brc_pkg.
`timescale 1ns / 1ps
`include "bitmap_range_clear_macros.svh"

module brc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  brc_pkg::dp_status_t status_i,
  output brc_pkg::cmd_t       cmd_o,
  output logic                busy_o
);
  import brc_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i && !status_i.special) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (status_i.last_word) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = start_i;
      end
      S_RUN: begin
        cmd_o.advance = 1'b1;
        busy_o        = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `BRC_ASSERT_NEXT(a_last_word_ends, clk_i, rst_ni,
    (state_q == S_RUN) && status_i.last_word, state_q == S_IDLE,
    "sequencer kept running past the final word")
  `BRC_ASSERT_NEXT(a_valid_load_runs, clk_i, rst_ni,
    cmd_o.load && !status_i.special, state_q == S_RUN,
    "accepted in-range request did not start the word sweep")
  `BRC_ASSERT_NOW(a_cmd_exclusive, clk_i, rst_ni,
    1'b1, !(cmd_o.load && cmd_o.advance),
    "load and advance issued together")

endmodule

[hw/rtl/bitmap_range_clear.sv]
// Top level of the bitmap range-clear block: controller plus datapath.
// Uses brc_pkg, brc_ctrl and brc_datapath.
//
//  channel   | ports                      | transfer
//  ----------+----------------------------+--------------------------------
//  request   | start, busy, req_i         | start high while busy low
//  result    | result_valid_o, result_o   | one-cycle strobe, no back-pressure
//
// A request touching N words keeps busy high while its words are swept and
// gives one result per cycle, each registered after the word's update in the
// run state; the next request can be taken in the cycle the last result shows.
// One bitmap word is read, masked and written back per cycle. Empty or
// out-of-range requests leave busy low and give one result the next cycle.
// Reset is asynchronous; per-word valid flops make unwritten words read as ones.
`timescale 1ns / 1ps

module bitmap_range_clear #(
  parameter int unsigned BitmapBits = brc_pkg::BitmapBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  brc_pkg::req_t req_i,
  output brc_pkg::res_t result_o,
  output logic          result_valid_o
);
  import brc_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_status;

  brc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (dp_status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  brc_datapath #(
    .BitmapBits (BitmapBits)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule
